### hdl/kkg_pkg.sv
// ----------------------------------------------------------------------------
// kkg_pkg
// Shared types and constants of the k-mer key generator.
// ----------------------------------------------------------------------------
package kkg_pkg;

  localparam int unsigned MaxK = 32;
  localparam int unsigned WinW = 2 * MaxK;
  localparam int unsigned KW = 6;
  localparam int unsigned ModW = 33;

  localparam logic [7:0] FirstPrintable = 8'd33;
  localparam logic [2:0] CodeN = 3'd4;

  localparam logic [1:0] ModePlain = 2'd0;
  localparam logic [1:0] ModeCToT = 2'd1;
  localparam logic [1:0] ModeGToA = 2'd2;

  localparam logic [1:0] RegKmerLength = 2'd0;
  localparam logic [1:0] RegModulus = 2'd1;
  localparam logic [1:0] RegConversionMode = 2'd2;

  typedef struct packed {
    logic [WinW-1:0] window;
    logic [31:0]     window_start;
    logic            key_valid;
  } kkg_job_t;

  typedef struct packed {
    logic [31:0] window_start;
    logic [31:0] key;
    logic        key_valid;
  } kkg_result_t;

endpackage

### hdl/kkg_if.sv
// ----------------------------------------------------------------------------
// kkg_in_if / kkg_out_if
// Valid/ready channels of the k-mer key generator.
// ----------------------------------------------------------------------------
interface kkg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  modport source (output valid, output base_char, input ready);
  modport sink (input valid, input base_char, output ready);
endinterface

interface kkg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] window_start;
  logic [31:0] key;
  logic        key_valid;
  modport source (output valid, output window_start, output key, output key_valid, input ready);
  modport sink (input valid, input window_start, input key, input key_valid, output ready);
endinterface

### hdl/kkg_front.sv
// ----------------------------------------------------------------------------
// kkg_front
// Classifies bytes, keeps the rolling window and counters, emits jobs.
// ----------------------------------------------------------------------------
module kkg_front (
  input  logic                 clk,
  input  logic                 rst,
  kkg_in_if.sink               in_ch,
  input  logic [5:0]           kmer_length,
  input  logic [1:0]           conversion_mode,
  output logic                 job_valid,
  output kkg_pkg::kkg_job_t    job,
  input  logic                 job_ready
);
  import kkg_pkg::*;

  logic [WinW-1:0] packed_window, win_next, mask;
  logic [5:0]      bases_since_unknown, bsu_next;
  logic [31:0]     base_count, cnt_next;
  logic [6:0]      k;
  logic [2:0]      code;
  logic [7:0]      up;
  logic            take;

  assign in_ch.ready = job_ready;
  assign take = in_ch.valid && job_ready && (in_ch.base_char >= FirstPrintable);

  always_comb begin
    k = (kmer_length == 6'd0 || kmer_length > 6'(MaxK)) ? 7'(MaxK) : {1'b0, kmer_length};
    mask = (k >= 7'(MaxK)) ? '1 : ((WinW'(1) << (2 * k)) - WinW'(1));
    up = in_ch.base_char;
    if (up >= 8'h61 && up <= 8'h7a) begin
      up = up - 8'h20;
    end
    case (up)
      8'h41: code = 3'd0;
      8'h43: code = (conversion_mode == ModeCToT) ? 3'd3 : 3'd1;
      8'h47: code = (conversion_mode == ModeGToA) ? 3'd0 : 3'd2;
      8'h54: code = 3'd3;
      default: code = CodeN;
    endcase
    if (in_ch.base_char[7]) begin
      code = CodeN;
    end
    if (code == CodeN) begin
      win_next = (packed_window << 2) & mask;
      bsu_next = '0;
    end else begin
      win_next = ((packed_window << 2) | WinW'(code[1:0])) & mask;
      bsu_next = (bases_since_unknown < 6'd63) ? bases_since_unknown + 6'd1
                                                 : bases_since_unknown;
    end
    cnt_next = base_count + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packed_window <= '0;
      bases_since_unknown <= '0;
      base_count <= '0;
      job_valid <= 1'b0;
    end else begin
      if (take) begin
        packed_window <= win_next;
        bases_since_unknown <= bsu_next;
        base_count <= cnt_next;
        job_valid <= (cnt_next >= 32'(k));
        job.window <= win_next;
        job.window_start <= cnt_next - 32'(k);
        job.key_valid <= ({1'b0, bsu_next} >= k);
      end else if (job_ready) begin
        job_valid <= 1'b0;
      end
    end
  end

endmodule

### hdl/kkg_queue.sv
// ----------------------------------------------------------------------------
// kkg_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module kkg_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  input  kkg_pkg::kkg_job_t  wr_data,
  output logic               wr_ready,
  output logic               rd_valid,
  output kkg_pkg::kkg_job_t  rd_data,
  input  logic               rd_ready
);
  import kkg_pkg::*;

  kkg_job_t   mem [2];
  logic       wp, rp;
  logic [1:0] count;
  logic       push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data = mem[rp];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_data;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### hdl/kkg_back.sv
// ----------------------------------------------------------------------------
// kkg_back
// Reduces a valid window by a nonzero modulus with a restoring shift-subtract divider.
// ----------------------------------------------------------------------------
module kkg_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  kkg_pkg::kkg_job_t    job,
  output logic                 job_ready,
  input  logic [32:0]          modulus,
  output logic                 res_valid,
  output kkg_pkg::kkg_result_t res,
  input  logic                 res_ready
);
  import kkg_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;

  state_t          state;
  logic [WinW-1:0] dividend;
  logic [ModW:0]   rem, rem_sh, diff;
  logic [ModW-1:0] divisor;
  logic [5:0]      step;
  logic [31:0]     start;
  logic            valid_flag;

  assign job_ready = (state == S_IDLE);
  assign res_valid = (state == S_OUT);

  always_comb begin
    rem_sh = {rem[ModW-1:0], dividend[WinW-1]};
    diff = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            dividend <= job.window;
            divisor <= modulus;
            start <= job.window_start;
            valid_flag <= job.key_valid;
            rem <= '0;
            step <= '0;
            if (!job.key_valid || modulus == '0) begin
              res.window_start <= job.window_start;
              res.key_valid <= job.key_valid;
              res.key <= job.key_valid ? job.window[31:0] : 32'd0;
              state <= S_OUT;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          dividend <= dividend << 1;
          rem <= diff[ModW] ? rem_sh : diff;
          step <= step + 6'd1;
          if (step == 6'(WinW - 1)) begin
            res.window_start <= start;
            res.key_valid <= valid_flag;
            res.key <= diff[ModW] ? rem_sh[31:0] : diff[31:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/kmer_key_generator_unit.sv
// ----------------------------------------------------------------------------
// kmer_key_generator_unit
// Rolling 2-bit k-mer key generator with modulo reduction.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  in_ch    | in  | base_char[7:0]
//  out_ch   | out | window_start[31:0], key[31:0], key_valid
//  apb      | in  | kmer_length @0x0, modulus @0x8, conversion_mode @0x10
//
// The front part takes one byte per cycle while the queue has room. A valid
// key runs through the serial divider bit by bit; invalid windows and a zero
// modulus skip it. The back part takes a new window only when idle.
// Reset is synchronous, clears the window and counters, presets the registers.
// A two-entry queue lets the front run while the divider or the sink stalls.
module kmer_key_generator_unit (
  input  logic        clk,
  input  logic        rst,
  kkg_in_if.sink      in_ch,
  kkg_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import kkg_pkg::*;

  logic [5:0]  kmer_length;
  logic [32:0] modulus;
  logic [1:0]  conversion_mode;
  logic [1:0]  reg_idx;
  logic        f_valid, f_ready, b_valid, b_ready;
  kkg_job_t    f_job, b_job;
  kkg_result_t res;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:3];

  always_comb begin
    case (reg_idx)
      RegKmerLength: prdata = 64'(kmer_length);
      RegModulus: prdata = 64'(modulus);
      RegConversionMode: prdata = 64'(conversion_mode);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= 6'd32;
      modulus <= 33'd536870911;
      conversion_mode <= ModePlain;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      case (reg_idx)
        RegKmerLength: kmer_length <= pwdata[5:0];
        RegModulus: modulus <= pwdata[32:0];
        RegConversionMode: conversion_mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  kkg_front u_front (
    .clk, .rst, .in_ch, .kmer_length, .conversion_mode,
    .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
  );

  kkg_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_data(f_job), .wr_ready(f_ready),
    .rd_valid(b_valid), .rd_data(b_job), .rd_ready(b_ready)
  );

  kkg_back u_back (
    .clk, .rst, .job_valid(b_valid), .job(b_job), .job_ready(b_ready),
    .modulus, .res_valid(out_ch.valid), .res, .res_ready(out_ch.ready)
  );

  assign out_ch.window_start = res.window_start;
  assign out_ch.key = res.key;
  assign out_ch.key_valid = res.key_valid;

endmodule

### sim/kmer_key_generator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kmer_key_generator_unit_tb
// Streams sequence bytes into the k-mer key generator under several register
// settings and handshake patterns, and checks every key transaction against
// a rolling-window predictor kept in the testbench, or literal keys in directed rows.
// ----------------------------------------------------------------------------
module kmer_key_generator_unit_tb;
  import kkg_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 80;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [63:0] reg_val;
    logic [7:0]  ch;
    bit          lit_en;
    kkg_result_t lit;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  kkg_in_if  in_ch ();
  kkg_out_if out_ch ();

  kmer_key_generator_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [5:0]  cur_k;
  logic [32:0] cur_mod;
  logic [1:0]  cur_mode;
  logic [63:0] win_bits;
  logic [5:0]  run_len;
  logic [31:0] base_total;

  kkg_result_t expected_keys[$];
  bit          lit_pending;
  kkg_result_t lit_value;
  int unsigned mismatches = 0;
  int unsigned keys_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycles = 0;
  int          idle_mode = 0;

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.base_char = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [2:0] map_base(logic [7:0] ch);
    logic [7:0] u;
    logic [2:0] c;
    u = ch;
    if (ch >= 8'd128) return CodeN;
    if (u >= "a" && u <= "z") u = u - 8'd32;
    case (u)
      "A": c = 3'd0;
      "C": c = 3'd1;
      "G": c = 3'd2;
      "T": c = 3'd3;
      default: return CodeN;
    endcase
    if (cur_mode == ModeCToT && c == 3'd1) c = 3'd3;
    else if (cur_mode == ModeGToA && c == 3'd2) c = 3'd0;
    return c;
  endfunction

  task automatic roll_base(input logic [7:0] ch);
    logic [2:0]  code;
    int unsigned k;
    logic [63:0] mask;
    logic [63:0] key;
    kkg_result_t r;
    if (ch < FirstPrintable) return;
    k = (cur_k == 0 || cur_k > MaxK) ? MaxK : cur_k;
    mask = (k >= 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
    code = map_base(ch);
    if (code == CodeN) begin
      win_bits = (win_bits << 2) & mask;
      run_len = '0;
    end else begin
      win_bits = ((win_bits << 2) | code[1:0]) & mask;
      if (run_len < 6'd63) run_len = run_len + 6'd1;
    end
    base_total = base_total + 32'd1;
    if (base_total < k) return;
    r.key_valid = (run_len >= k);
    if (!r.key_valid) key = '0;
    else if (cur_mod == 0) key = win_bits;
    else key = win_bits % {31'd0, cur_mod};
    r.window_start = base_total - k;
    r.key = key[31:0];
    expected_keys.insert(expected_keys.size(), lit_pending ? lit_value : r);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 3'b000}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    case (idx)
      RegKmerLength: cur_k = val[5:0];
      RegModulus: cur_mod = val[32:0];
      RegConversionMode: cur_mode = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic drain();
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] ch);
    @(negedge clk);
    while ((idle_mode == 1 && $urandom_range(99) < 61) ||
           (idle_mode == 3 && $urandom_range(99) < 16)) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.base_char = ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    roll_base(ch);
    bytes_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic [7:0] random_char();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 80) begin
      case ($urandom_range(3))
        0: return ($urandom_range(1) != 0) ? "A" : "a";
        1: return ($urandom_range(1) != 0) ? "C" : "c";
        2: return ($urandom_range(1) != 0) ? "G" : "g";
        default: return ($urandom_range(1) != 0) ? "T" : "t";
      endcase
    end
    if (sel < 85) return ($urandom_range(1) != 0) ? "N" : "n";
    if (sel < 90) return 8'($urandom_range(32));
    if (sel < 93) return 8'($urandom_range(255, 128));
    return 8'($urandom_range(255));
  endfunction

  always @(negedge clk) begin
    case (idle_mode)
      2: out_ch.ready <= ($urandom_range(99) >= 61);
      3: out_ch.ready <= ($urandom_range(99) >= 16);
      default: out_ch.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    kkg_result_t exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      keys_seen++;
      if (expected_keys.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected key transaction: start %0d key %0h valid %0b",
                   out_ch.window_start, out_ch.key, out_ch.key_valid);
      end else begin
        exp_r = expected_keys.pop_front();
        if (out_ch.window_start !== exp_r.window_start || out_ch.key !== exp_r.key ||
            out_ch.key_valid !== exp_r.key_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("key mismatch: expected start %0d key %0h valid %0b, got %0d %0h %0b",
                     exp_r.window_start, exp_r.key, exp_r.key_valid,
                     out_ch.window_start, out_ch.key, out_ch.key_valid);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("kmer_key_generator_unit_tb failed");
      $finish;
    end
  end

  function automatic stim_row_t cfg_row(logic [1:0] idx, logic [63:0] val);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1; r.reg_idx = idx; r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t byte_row(logic [7:0] ch);
    stim_row_t r;
    r = '{default: '0};
    r.ch = ch;
    return r;
  endfunction

  function automatic stim_row_t lit_row(logic [7:0] ch, logic [31:0] st, logic [31:0] key,
                                        logic vld);
    stim_row_t r;
    r = byte_row(ch);
    r.lit_en = 1'b1;
    r.lit.window_start = st; r.lit.key = key; r.lit.key_valid = vld;
    return r;
  endfunction

  stim_row_t directed[$];
  logic [63:0] phase_k[12] = '{1, 32, 0, 63, 5, 12, 20, 31, 3, 16, 32, 8};
  logic [63:0] phase_mod[12] = '{0, 64'h1_0000_0000, 1, 536870911, 7, 0, 64'hFFFF_FFFF,
                                  1000003, 2, 64'h1_FFFF_FFFF, 97, 13};
  logic [63:0] phase_mode[12] = '{0, 1, 2, 3, 0, 1, 2, 0, 3, 0, 1, 2};

  initial begin
    int n;
    cur_k = 6'd32; cur_mod = 33'd536870911; cur_mode = ModePlain;
    win_bits = '0; run_len = '0; base_total = '0;
    lit_pending = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed = {directed, cfg_row(RegKmerLength, 1)};
    directed = {directed, cfg_row(RegModulus, 0)};
    directed = {directed, lit_row("T", 0, 3, 1)};
    directed = {directed, lit_row("N", 1, 0, 0)};
    directed = {directed, byte_row(8'd32)};
    directed = {directed, byte_row(8'd0)};
    directed = {directed, lit_row("g", 2, 2, 1)};
    directed = {directed, lit_row(8'hFF, 3, 0, 0)};
    directed = {directed, lit_row(8'd128, 4, 0, 0)};
    directed = {directed, lit_row("a", 5, 0, 1)};
    directed = {directed, lit_row("c", 6, 1, 1)};
    directed = {directed, cfg_row(RegConversionMode, ModeCToT)};
    directed = {directed, lit_row("C", 7, 3, 1)};
    directed = {directed, cfg_row(RegConversionMode, ModeGToA)};
    directed = {directed, lit_row("G", 8, 0, 1)};
    directed = {directed, cfg_row(RegConversionMode, 3)};
    directed = {directed, lit_row("G", 9, 2, 1)};
    directed = {directed, cfg_row(RegKmerLength, 3)};
    directed = {directed, cfg_row(RegModulus, 5)};
    directed = {directed, byte_row("T")};
    directed = {directed, byte_row(8'd33)};
    directed = {directed, byte_row("t")};
    directed = {directed, byte_row("t")};
    directed = {directed, byte_row("t")};
    directed = {directed, byte_row(8'd127)};

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        stop_sending();
        drain();
        reg_write(directed[i].reg_idx, directed[i].reg_val);
      end else begin
        lit_pending = directed[i].lit_en;
        lit_value = directed[i].lit;
        send_byte(directed[i].ch);
        lit_pending = 1'b0;
      end
    end

    for (int p = 0; p < 12; p++) begin
      stop_sending();
      drain();
      reg_write(RegKmerLength, phase_k[p]);
      reg_write(RegModulus, phase_mod[p]);
      reg_write(RegConversionMode, phase_mode[p]);
      idle_mode = p % 4;
      n = 150;
      for (int i = 0; i < n; i++) send_byte(random_char());
    end
    stop_sending();

    while (expected_keys.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Sent %0d sequence bytes over 12 register settings and 4 handshake patterns;",
             bytes_sent);
    $display("checked %0d key transactions, %0d mismatches.", keys_seen, mismatches);
    if (mismatches == 0 && expected_keys.size() == 0) begin
      $display("kmer_key_generator_unit_tb passed");
    end else begin
      $display("kmer_key_generator_unit_tb failed");
    end
    $finish;
  end

endmodule
